@@ src/tpc_pkg.sv @@
`default_nettype none

package tpc_pkg;

    localparam int TIME_BITS_DEF = 32;
    localparam int SAMPLE_W      = 22;
    localparam int HOLD_W        = 16;
    localparam int EN_W          = 10;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = SAMPLE_W;

    localparam logic [SAMPLE_W-1:0] STEP_RESET     = SAMPLE_W'(10000);
    localparam logic [HOLD_W-1:0]   SHORT_RESET    = HOLD_W'(100);
    localparam logic [HOLD_W-1:0]   LONG_RESET     = HOLD_W'(1000);
    localparam logic [HOLD_W-1:0]   COOLDOWN_RESET = HOLD_W'(500);

    localparam logic [CFG_IDX_W-1:0] REG_TOUCH_MARGIN   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR_A  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NOISE_FLOOR_B  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SHORT_HOLD     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_LONG_HOLD      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_COOLDOWN       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_HANDLER_ENABLE = 3'd6;

    localparam int EN_TOUCH   = 0;
    localparam int EN_RELEASE = 1;
    localparam int EN_SHORT   = 2;
    localparam int EN_LONG    = 3;
    localparam int EN_ZONE1   = 4;
    localparam int EN_BOTH_SHORT = 8;
    localparam int EN_BOTH_LONG  = 9;

    typedef struct packed {
        logic [SAMPLE_W-1:0] touch_margin;
        logic [SAMPLE_W-1:0] noise_floor_a;
        logic [SAMPLE_W-1:0] noise_floor_b;
        logic [HOLD_W-1:0]   short_hold_ms;
        logic [HOLD_W-1:0]   long_hold_ms;
        logic [HOLD_W-1:0]   cooldown_ms;
        logic [EN_W-1:0]     handler_enable;
    } tpc_cfg_t;

    typedef struct packed {
        logic event_zone;
        logic touch_flag;
        logic release_flag;
        logic short_flag;
        logic long_flag;
        logic both_short_flag;
        logic both_long_flag;
    } tpc_result_t;

endpackage

`default_nettype wire

@@ src/tpc_cfg.sv @@
`default_nettype none

module tpc_cfg
    import tpc_pkg::*;
(
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    output tpc_cfg_t                   cfg
);

    tpc_cfg_t cfg_reg;
    tpc_cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_we) begin
            case (cfg_index)
                REG_TOUCH_MARGIN:   cfg_next.touch_margin   = cfg_data[SAMPLE_W-1:0];
                REG_NOISE_FLOOR_A:  cfg_next.noise_floor_a  = cfg_data[SAMPLE_W-1:0];
                REG_NOISE_FLOOR_B:  cfg_next.noise_floor_b  = cfg_data[SAMPLE_W-1:0];
                REG_SHORT_HOLD:     cfg_next.short_hold_ms  = cfg_data[HOLD_W-1:0];
                REG_LONG_HOLD:      cfg_next.long_hold_ms   = cfg_data[HOLD_W-1:0];
                REG_COOLDOWN:       cfg_next.cooldown_ms    = cfg_data[HOLD_W-1:0];
                REG_HANDLER_ENABLE: cfg_next.handler_enable = cfg_data[EN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.touch_margin   <= STEP_RESET;
            cfg_reg.noise_floor_a  <= '0;
            cfg_reg.noise_floor_b  <= '0;
            cfg_reg.short_hold_ms  <= SHORT_RESET;
            cfg_reg.long_hold_ms   <= LONG_RESET;
            cfg_reg.cooldown_ms    <= COOLDOWN_RESET;
            cfg_reg.handler_enable <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

@@ src/tpc_core.sv @@
`default_nettype none

module tpc_core
    import tpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire tpc_cfg_t             cfg,
    input  wire logic                 advance,
    input  wire logic                 zone,
    input  wire logic                 rising,
    input  wire logic [TIME_BITS-1:0] now_ms,
    input  wire logic [SAMPLE_W-1:0]  other_reading,
    output tpc_result_t               result
);

    localparam int SUM_W = (SAMPLE_W + 1 > 32) ? 32 : SAMPLE_W + 1;

    logic [TIME_BITS-1:0] touch_time_reg [2];
    logic [TIME_BITS-1:0] touch_time_next [2];
    logic [TIME_BITS-1:0] release_time_reg [2];
    logic [TIME_BITS-1:0] release_time_next [2];
    logic [TIME_BITS-1:0] last_bs_reg, last_bs_next;
    logic [TIME_BITS-1:0] last_bl_reg, last_bl_next;

    logic                 oz;
    logic [3:0]           zen;
    logic [SAMPLE_W-1:0]  floor_o;
    logic [SUM_W-1:0]     thresh;
    logic                 other_touched, other_recent, other_active;
    logic [TIME_BITS-1:0] short_t, long_t, cool_t;
    logic [TIME_BITS-1:0] elapsed_o;
    logic                 held_short, held_long, o_short, o_long;
    logic                 bs_ready, bl_ready;
    logic                 f_short, f_long, f_bs, f_bl;

    assign oz      = ~zone;
    assign zen     = zone ? cfg.handler_enable[EN_ZONE1 +: 4] : cfg.handler_enable[3:0];
    assign floor_o = oz ? cfg.noise_floor_b : cfg.noise_floor_a;
    assign thresh  = SUM_W'({1'b0, floor_o} + {1'b0, cfg.touch_margin});
    assign other_touched = SUM_W'(other_reading) > thresh;

    assign short_t = TIME_BITS'(cfg.short_hold_ms);
    assign long_t  = TIME_BITS'(cfg.long_hold_ms);
    assign cool_t  = TIME_BITS'(cfg.cooldown_ms);

    assign elapsed_o    = now_ms - release_time_reg[oz];
    assign other_recent = elapsed_o < cool_t;
    assign other_active = other_touched || other_recent;

    assign held_short = TIME_BITS'(touch_time_reg[zone] + short_t) < now_ms;
    assign held_long  = TIME_BITS'(touch_time_reg[zone] + long_t) < now_ms;
    assign o_short    = TIME_BITS'(touch_time_reg[oz] + short_t) < now_ms;
    assign o_long     = TIME_BITS'(touch_time_reg[oz] + long_t) < now_ms;
    assign bs_ready   = TIME_BITS'(last_bs_reg + cool_t) < now_ms;
    assign bl_ready   = TIME_BITS'(last_bl_reg + cool_t) < now_ms;

    assign f_short = !rising && zen[EN_SHORT] && held_short;
    assign f_long  = !rising && zen[EN_LONG] && held_long;
    assign f_bs    = f_short && cfg.handler_enable[EN_BOTH_SHORT] && bs_ready
                     && other_active && o_short;
    assign f_bl    = f_long && cfg.handler_enable[EN_BOTH_LONG] && bl_ready
                     && other_active && o_long;

    always_comb begin
        touch_time_next   = touch_time_reg;
        release_time_next = release_time_reg;
        last_bs_next      = last_bs_reg;
        last_bl_next      = last_bl_reg;
        if (rising) begin
            touch_time_next[zone] = now_ms;
        end else begin
            release_time_next[zone] = now_ms;
        end
        if (f_bs) begin
            last_bs_next = now_ms;
        end
        if (f_bl) begin
            last_bl_next = now_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            touch_time_reg   <= '{default: '0};
            release_time_reg <= '{default: '0};
            last_bs_reg      <= '0;
            last_bl_reg      <= '0;
        end else if (advance) begin
            touch_time_reg   <= touch_time_next;
            release_time_reg <= release_time_next;
            last_bs_reg      <= last_bs_next;
            last_bl_reg      <= last_bl_next;
        end
    end

    always_comb begin
        result.event_zone      = zone;
        result.touch_flag      = rising && zen[EN_TOUCH];
        result.release_flag    = !rising && zen[EN_RELEASE];
        result.short_flag      = f_short;
        result.long_flag       = f_long;
        result.both_short_flag = f_bs;
        result.both_long_flag  = f_bl;
    end

endmodule

`default_nettype wire

@@ src/touch_press_classifier.sv @@
// Touch press classifier for two touch zones.
// Input channel (s_valid/s_ready): one beat per touch or release edge, with
// its zone, direction, millisecond time and the other zone's raw reading.
// Result channel (m_valid/m_ready): exactly one beat per input beat, carrying
// the zone and the touch, release, short, long and both-zone gesture flags.
// Configuration: cfg_we writes cfg_data into the register selected by cfg_index;
// write only while no beat is in flight.
// Path: an accepted beat is held in the input register, the flags and the
// per-zone time records are computed from it combinationally, and the result
// is then registered into the result register that drives m_*.
// Throughput: one beat per cycle while the receiver keeps m_ready high; a low
// m_ready holds the result register and so holds the flow.
// Stall: when m_ready is low the result register holds, the input register
// still takes one more beat if empty, then s_ready drops until the result is taken.
// Reset (aresetn low, synchronous): both registers empty, time records zero,
// configuration back to its defaults.
`default_nettype none

module touch_press_classifier
    import tpc_pkg::*;
#(
    parameter int TIME_BITS = TIME_BITS_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,

    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,

    input  wire logic                  s_valid,
    output logic                       s_ready,
    input  wire logic                  s_zone,
    input  wire logic                  s_rising,
    input  wire logic [TIME_BITS-1:0]  s_now_ms,
    input  wire logic [SAMPLE_W-1:0]   s_other_reading,

    output logic                       m_valid,
    input  wire logic                  m_ready,
    output logic                       m_event_zone,
    output logic                       m_touch_flag,
    output logic                       m_release_flag,
    output logic                       m_short_flag,
    output logic                       m_long_flag,
    output logic                       m_both_short_flag,
    output logic                       m_both_long_flag
);

    tpc_cfg_t             cfg;
    tpc_result_t          result;
    tpc_result_t          out_reg;

    logic                 in_valid_reg;
    logic                 zone_reg;
    logic                 rising_reg;
    logic [TIME_BITS-1:0] now_reg;
    logic [SAMPLE_W-1:0]  other_reg;
    logic                 out_valid_reg;
    logic                 advance;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    tpc_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    tpc_core #(
        .TIME_BITS (TIME_BITS)
    ) u_core (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg),
        .advance       (advance),
        .zone          (zone_reg),
        .rising        (rising_reg),
        .now_ms        (now_reg),
        .other_reading (other_reg),
        .result        (result)
    );

    // take a new beat whenever the input register empties
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            zone_reg   <= s_zone;
            rising_reg <= s_rising;
            now_reg    <= s_now_ms;
            other_reg  <= s_other_reading;
        end
    end

    // hold the result while the receiver stalls
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!out_valid_reg || m_ready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_reg <= result;
        end
    end

    assign m_valid           = out_valid_reg;
    assign m_event_zone      = out_reg.event_zone;
    assign m_touch_flag      = out_reg.touch_flag;
    assign m_release_flag    = out_reg.release_flag;
    assign m_short_flag      = out_reg.short_flag;
    assign m_long_flag       = out_reg.long_flag;
    assign m_both_short_flag = out_reg.both_short_flag;
    assign m_both_long_flag  = out_reg.both_long_flag;

endmodule

`default_nettype wire
